// ===== rtl/twdbm_pkg.sv =====
// Shared types and constants for the two-wire display bus master.
// No dependencies; used by twdbm_tick and the top level.
package twdbm_pkg;

   localparam int BITS_PER_BYTE = 8;

   // Phase at which the bit loop of a write ends (three ticks per bit)
   localparam logic [4:0] WR_BITS_END = 5'(3 * BITS_PER_BYTE);
   // Phase at which the bit loop of a read ends (two ticks per bit)
   localparam logic [4:0] RD_BITS_END = 5'(2 * BITS_PER_BYTE);

   typedef enum logic [2:0] {
      OP_IDLE  = 3'd0,
      OP_START = 3'd1,
      OP_WRITE = 3'd2,
      OP_READ  = 3'd3,
      OP_STOP  = 3'd4
   } op_type;

   // Sub-step of one written bit: set DIO, raise CLK, lower CLK
   typedef enum logic [1:0] {
      SUB_DATA = 2'd0,
      SUB_RISE = 2'd1,
      SUB_FALL = 2'd2
   } sub_type;

   typedef struct packed {
      op_type     op;
      logic [4:0] phase;
      sub_type    sub;
      logic [7:0] shift;
      logic       clk_level;
      logic       dio_level;
      logic       drive_en;
   } state_type;

   typedef struct packed {
      logic       read_valid;
      logic [7:0] read_byte;
      logic       ready_res;
      logic       dio_drive;
      logic       dio_out;
      logic       clk_out;
   } result_type;

endpackage

// ===== rtl/two_wire_display_bus_master_top.sv =====
// Top level of the two-wire display bus master: stream ports, state and result registers.
// Depends on twdbm_pkg and twdbm_tick.
// Latency: the result of a tick request is on rsp_* the cycle after it is accepted.
// Throughput: one tick request per clock; the single result register is refilled
//   in the same cycle it is drained, so req_tready only drops while a result waits.
// Reset: synchronous, active high; bus idle with CLK and DIO high and DIO driven.
module two_wire_display_bus_master_top (
   input  logic        clock,
   input  logic        reset,
   // tick request channel
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [2:0]  req_tuser,   // [2:0] func
   input  logic [15:0] req_tdata,   // [7:0] send_byte, [8] dio_in, [15:9] zero
   // result channel
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [15:0] rsp_tdata    // [0] clk_out, [1] dio_out, [2] dio_drive,
                                    // [3] ready_res, [11:4] read_byte,
                                    // [12] read_valid, [15:13] zero
);
   import twdbm_pkg::*;

   state_type  state_ff;
   state_type  state_in;
   result_type rsp_ff;
   result_type rsp_in;
   logic       rsp_valid_ff;
   logic       req_accept;

   // accept whenever the result register is empty or is being drained
   assign req_tready = !rsp_valid_ff || rsp_tready;
   assign req_accept = req_tvalid && req_tready;

   twdbm_tick u_tick (
      .st        (state_ff),
      .func      (req_tuser),
      .send_byte (req_tdata[7:0]),
      .dio_in    (req_tdata[8]),
      .st_next   (state_in),
      .res       (rsp_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff.op        <= OP_IDLE;
         state_ff.phase     <= '0;
         state_ff.sub       <= SUB_DATA;
         state_ff.shift     <= '0;
         state_ff.clk_level <= 1'b1;
         state_ff.dio_level <= 1'b1;
         state_ff.drive_en  <= 1'b1;
         rsp_valid_ff       <= 1'b0;
      end else begin
         // advance the sequencer one tick per accepted request
         if (req_accept) begin
            state_ff     <= state_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // payload holds while the result waits
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {3'b000, rsp_ff.read_valid, rsp_ff.read_byte, rsp_ff.ready_res,
                        rsp_ff.dio_drive, rsp_ff.dio_out, rsp_ff.clk_out};

endmodule

// ===== rtl/twdbm_tick.sv =====
// One bit-delay tick of the bus sequencer: next state and line levels.
// Depends on twdbm_pkg.
module twdbm_tick (
   input  twdbm_pkg::state_type  st,
   input  logic [2:0]            func,
   input  logic [7:0]            send_byte,
   input  logic                  dio_in,
   output twdbm_pkg::state_type  st_next,
   output twdbm_pkg::result_type res
);
   import twdbm_pkg::*;

   state_type cur;
   state_type nxt;
   logic      valid;

   always_comb begin
      // take a request only while idle; unknown codes count as none
      cur = st;
      if (st.op == OP_IDLE && func >= 3'(OP_START) && func <= 3'(OP_STOP)) begin
         cur.op    = op_type'(func);
         cur.phase = '0;
         cur.sub   = SUB_DATA;
         if (op_type'(func) == OP_WRITE) begin
            cur.shift = send_byte;
         end
      end

      nxt   = cur;
      valid = 1'b0;
      unique case (cur.op)
         OP_IDLE: begin
            // hold the lines
         end
         OP_START: begin
            if (cur.phase == 5'd0) begin
               nxt.dio_level = 1'b0;
               nxt.phase     = 5'd1;
            end else begin
               nxt.clk_level = 1'b0;
               nxt.op        = OP_IDLE;
               nxt.phase     = '0;
            end
         end
         OP_STOP: begin
            priority if (cur.phase == 5'd0) begin
               nxt.dio_level = 1'b0;
               nxt.phase     = 5'd1;
            end else if (cur.phase == 5'd1) begin
               nxt.clk_level = 1'b1;
               nxt.phase     = 5'd2;
            end else begin
               nxt.dio_level = 1'b1;
               nxt.op        = OP_IDLE;
               nxt.phase     = '0;
            end
         end
         OP_WRITE: begin
            priority if (cur.phase < WR_BITS_END) begin
               unique case (cur.sub)
                  SUB_DATA: begin
                     nxt.dio_level = cur.shift[0];
                     nxt.sub       = SUB_RISE;
                  end
                  SUB_RISE: begin
                     nxt.clk_level = 1'b1;
                     nxt.sub       = SUB_FALL;
                  end
                  default: begin
                     nxt.clk_level = 1'b0;
                     nxt.shift     = {1'b0, cur.shift[7:1]};
                     nxt.sub       = SUB_DATA;
                  end
               endcase
               nxt.phase = cur.phase + 5'd1;
            end else if (cur.phase == WR_BITS_END) begin
               // release DIO for the acknowledge clock
               nxt.dio_level = 1'b1;
               nxt.drive_en  = 1'b0;
               nxt.phase     = cur.phase + 5'd1;
            end else if (cur.phase == WR_BITS_END + 5'd1) begin
               nxt.clk_level = 1'b1;
               nxt.phase     = cur.phase + 5'd1;
            end else if (cur.phase == WR_BITS_END + 5'd2) begin
               nxt.clk_level = 1'b0;
               nxt.phase     = cur.phase + 5'd1;
            end else begin
               nxt.drive_en  = 1'b1;
               nxt.dio_level = 1'b1;
               nxt.op        = OP_IDLE;
               nxt.phase     = '0;
               nxt.sub       = SUB_DATA;
            end
         end
         OP_READ: begin
            priority if (cur.phase == 5'd0) begin
               nxt.drive_en = 1'b0;
               nxt.shift    = '0;
               nxt.phase    = 5'd1;
            end else if (cur.phase <= RD_BITS_END) begin
               if (cur.phase[0]) begin
                  // sample while CLK is high, first bit ends in bit 7
                  nxt.clk_level = 1'b1;
                  nxt.shift     = {cur.shift[6:0], dio_in};
               end else begin
                  nxt.clk_level = 1'b0;
               end
               nxt.phase = cur.phase + 5'd1;
            end else if (cur.phase == RD_BITS_END + 5'd1) begin
               nxt.drive_en = 1'b1;
               nxt.phase    = cur.phase + 5'd1;
            end else if (cur.phase == RD_BITS_END + 5'd2) begin
               nxt.dio_level = 1'b0;
               nxt.phase     = cur.phase + 5'd1;
            end else if (cur.phase == RD_BITS_END + 5'd3) begin
               nxt.clk_level = 1'b1;
               nxt.phase     = cur.phase + 5'd1;
            end else begin
               nxt.clk_level = 1'b0;
               nxt.dio_level = 1'b1;
               nxt.op        = OP_IDLE;
               nxt.phase     = '0;
               valid         = 1'b1;
            end
         end
         default: begin
            nxt.op = OP_IDLE;
         end
      endcase
   end

   assign st_next        = nxt;
   assign res.clk_out    = nxt.clk_level;
   assign res.dio_out    = nxt.dio_level;
   assign res.dio_drive  = nxt.drive_en;
   assign res.ready_res  = (nxt.op == OP_IDLE);
   assign res.read_byte  = valid ? nxt.shift : 8'd0;
   assign res.read_valid = valid;

endmodule

// ===== bench/two_wire_display_bus_master_top_tb.sv =====
// Self-checking bench for the two-wire display bus master: tick requests in, line states out.
// Keeps its own tick-level model of the bus sequences and checks every result against it.
// Depends on twdbm_pkg and two_wire_display_bus_master_top.
module two_wire_display_bus_master_top_tb;
   import twdbm_pkg::*;

   // Request codes outside the package enum; the block must treat them as no request
   localparam logic [2:0] FUNC_UNUSED_LO = 3'd5;
   localparam logic [2:0] FUNC_UNUSED_HI = 3'd7;
   localparam int         STALL_LIMIT    = 2000;
   localparam int         MAX_REPORTS    = 10;

   logic        clock      = 1'b0;
   logic        reset      = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [2:0]  req_tuser  = 3'd0;    // [2:0] func
   logic [15:0] req_tdata  = 16'd0;   // [7:0] send_byte, [8] dio_in, [15:9] zero
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [15:0] rsp_tdata;            // [0] clk_out, [1] dio_out, [2] dio_drive,
                                      // [3] ready_res, [11:4] read_byte,
                                      // [12] read_valid, [15:13] zero

   two_wire_display_bus_master_top uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tuser  (req_tuser),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always #2 clock = ~clock;

   // Bus model state
   op_type     bus_op;
   logic [4:0] bus_phase;
   logic [2:0] bus_bits;
   logic [7:0] bus_shift;
   logic       clk_lvl;
   logic       dio_lvl;
   logic       drv_en;

   result_type expected_line_states[$];
   int         send_idle_pct = 29;
   int         recv_idle_pct = 69;
   int         ticks_sent    = 0;
   int         error_count   = 0;
   int         stall_cycles  = 0;
   result_type got_state;
   result_type want_state;

   function automatic void reset_bus_model();
      bus_op    = OP_IDLE;
      bus_phase = 5'd0;
      bus_bits  = 3'd0;
      bus_shift = 8'd0;
      clk_lvl   = 1'b1;
      dio_lvl   = 1'b1;
      drv_en    = 1'b1;
   endfunction

   function automatic void end_bus_request();
      bus_op    = OP_IDLE;
      bus_phase = 5'd0;
      bus_bits  = 3'd0;
   endfunction

   // Advance the bus model by one tick and give the line state it leaves behind
   function automatic result_type predict_line_tick(logic [2:0] func, logic [7:0] data,
                                                    logic dio);
      result_type r;
      logic       done;
      done = 1'b0;
      if (bus_op == OP_IDLE && func >= OP_START && func <= OP_STOP) begin
         bus_op    = op_type'(func);
         bus_phase = 5'd0;
         bus_bits  = 3'd0;
         if (op_type'(func) == OP_WRITE) bus_shift = data;
      end
      case (bus_op)
         OP_START: begin
            if (bus_phase == 5'd0) begin
               dio_lvl   = 1'b0;
               bus_phase = 5'd1;
            end else begin
               clk_lvl = 1'b0;
               end_bus_request();
            end
         end
         OP_STOP: begin
            if (bus_phase == 5'd0) begin
               dio_lvl   = 1'b0;
               bus_phase = 5'd1;
            end else if (bus_phase == 5'd1) begin
               clk_lvl   = 1'b1;
               bus_phase = 5'd2;
            end else begin
               dio_lvl = 1'b1;
               end_bus_request();
            end
         end
         OP_WRITE: begin
            if (bus_phase < WR_BITS_END) begin
               case (bus_phase % 3)
                  0: dio_lvl = bus_shift[0];
                  1: clk_lvl = 1'b1;
                  default: begin
                     clk_lvl   = 1'b0;
                     bus_shift = bus_shift >> 1;
                     bus_bits  = bus_bits + 3'd1;
                  end
               endcase
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == WR_BITS_END) begin
               // release DIO for the dummy acknowledge
               dio_lvl   = 1'b1;
               drv_en    = 1'b0;
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == WR_BITS_END + 5'd1) begin
               clk_lvl   = 1'b1;
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == WR_BITS_END + 5'd2) begin
               clk_lvl   = 1'b0;
               bus_phase = bus_phase + 5'd1;
            end else begin
               drv_en  = 1'b1;
               dio_lvl = 1'b1;
               end_bus_request();
            end
         end
         OP_READ: begin
            if (bus_phase == 5'd0) begin
               drv_en    = 1'b0;
               bus_shift = 8'd0;
               bus_phase = 5'd1;
            end else if (bus_phase <= RD_BITS_END) begin
               // odd phases raise CLK and sample, even phases lower it
               if (bus_phase[0]) begin
                  clk_lvl   = 1'b1;
                  bus_shift = {bus_shift[6:0], dio};
               end else begin
                  clk_lvl  = 1'b0;
                  bus_bits = bus_bits + 3'd1;
               end
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == RD_BITS_END + 5'd1) begin
               drv_en    = 1'b1;
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == RD_BITS_END + 5'd2) begin
               dio_lvl   = 1'b0;
               bus_phase = bus_phase + 5'd1;
            end else if (bus_phase == RD_BITS_END + 5'd3) begin
               clk_lvl   = 1'b1;
               bus_phase = bus_phase + 5'd1;
            end else begin
               clk_lvl = 1'b0;
               dio_lvl = 1'b1;
               end_bus_request();
               done = 1'b1;
            end
         end
         default: ;
      endcase
      r.clk_out    = clk_lvl;
      r.dio_out    = dio_lvl;
      r.dio_drive  = drv_en;
      r.ready_res  = (bus_op == OP_IDLE);
      r.read_byte  = done ? bus_shift : 8'd0;
      r.read_valid = done;
      return r;
   endfunction

   // Offer one tick request, with random idle cycles first; predict once it is taken
   task automatic send_tick(input logic [2:0] func, input logic [7:0] data, input logic dio);
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {7'd0, dio, data};
      do @(posedge clock); while (!req_tready);
      expected_line_states.push_back(predict_line_tick(func, data, dio));
      ticks_sent++;
   endtask

   // Issue a bus request, then tick until the model is idle again. During a read the
   // data line follows line_bits, first bit from bit 7. noise_pct of the filler ticks
   // carry a random code, which the block must ignore while busy.
   task automatic run_request(input logic [2:0] func, input logic [7:0] data,
                              input logic [7:0] line_bits, input int noise_pct);
      logic [2:0] fill_func;
      logic       dio;
      send_tick(func, data, 1'($urandom));
      while (bus_op != OP_IDLE) begin
         fill_func = ($urandom_range(0, 99) < noise_pct) ? 3'($urandom_range(0, 7)) : OP_IDLE;
         dio = (bus_op == OP_READ) ? line_bits[3'd7 - bus_bits] : 1'($urandom);
         send_tick(fill_func, 8'($urandom), dio);
      end
   endtask

   // Hold the request channel low until every result is back
   task automatic drain_results();
      req_tvalid <= 1'b0;
      do @(posedge clock); while (expected_line_states.size() != 0);
   endtask

   task automatic test_idle_codes();
      logic [2:0] code;
      send_tick(OP_IDLE, 8'h00, 1'b0);
      for (code = FUNC_UNUSED_LO; code != 3'd0; code = code + 3'd1)
         send_tick(code, 8'hFF, 1'b1);
   endtask

   task automatic test_start_stop();
      run_request(OP_START, 8'h00, 8'h00, 0);
      run_request(OP_STOP, 8'hFF, 8'hFF, 0);
   endtask

   task automatic test_write_byte();
      // requests arriving mid-write must not disturb it
      run_request(OP_WRITE, 8'hFF, 8'h00, 50);
   endtask

   task automatic test_read_byte();
      run_request(OP_READ, 8'h00, 8'hFF, 0);
   endtask

   task automatic test_random_traffic(input int n_ticks);
      int         stop_at;
      int         pick;
      int         noise;
      logic [2:0] code;
      stop_at = ticks_sent + n_ticks;
      while (ticks_sent < stop_at) begin
         pick  = $urandom_range(0, 99);
         noise = ($urandom_range(0, 2) == 0) ? 20 : 0;
         if (pick < 10) begin
            code = (pick < 5) ? OP_IDLE : 3'($urandom_range(FUNC_UNUSED_LO, FUNC_UNUSED_HI));
            send_tick(code, 8'($urandom), 1'($urandom));
         end else if (pick < 22) begin
            run_request(OP_START, 8'($urandom), 8'($urandom), noise);
         end else if (pick < 52) begin
            run_request(OP_WRITE, 8'($urandom), 8'($urandom), noise);
         end else if (pick < 82) begin
            run_request(OP_READ, 8'($urandom), 8'($urandom), noise);
         end else begin
            run_request(OP_STOP, 8'($urandom), 8'($urandom), noise);
         end
      end
   endtask

   task automatic test_pause_until_drained();
      run_request(OP_WRITE, 8'($urandom), 8'h00, 0);
      drain_results();
      run_request(OP_READ, 8'h00, 8'($urandom), 0);
   endtask

   task automatic flag_field(input string name, input logic [7:0] want, input logic [7:0] got);
      error_count++;
      if (error_count <= MAX_REPORTS)
         $display("mismatch in %s: expected %0h, got %0h", name, want, got);
   endtask

   // Receiver stalls at random
   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(0, 99) >= recv_idle_pct);
   end

   // Compare each accepted result with the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_state = rsp_tdata[12:0];
         if (expected_line_states.size() == 0) begin
            error_count++;
            if (error_count <= MAX_REPORTS)
               $display("unexpected result %0h with nothing predicted", rsp_tdata);
         end else begin
            want_state = expected_line_states.pop_front();
            if (got_state.clk_out != want_state.clk_out)
               flag_field("clk_out", 8'(want_state.clk_out), 8'(got_state.clk_out));
            if (got_state.dio_out != want_state.dio_out)
               flag_field("dio_out", 8'(want_state.dio_out), 8'(got_state.dio_out));
            if (got_state.dio_drive != want_state.dio_drive)
               flag_field("dio_drive", 8'(want_state.dio_drive), 8'(got_state.dio_drive));
            if (got_state.ready_res != want_state.ready_res)
               flag_field("ready_res", 8'(want_state.ready_res), 8'(got_state.ready_res));
            if (got_state.read_byte != want_state.read_byte)
               flag_field("read_byte", want_state.read_byte, got_state.read_byte);
            if (got_state.read_valid != want_state.read_valid)
               flag_field("read_valid", 8'(want_state.read_valid),
                          8'(got_state.read_valid));
            if (rsp_tdata[15:13] != 3'd0)
               flag_field("padding", 8'd0, 8'(rsp_tdata[15:13]));
         end
      end
   end

   // Abort if neither channel moves for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

   initial begin
      reset_bus_model();
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      send_idle_pct = 29;
      recv_idle_pct = 69;
      test_idle_codes();
      test_start_stop();
      test_write_byte();
      test_read_byte();
      test_random_traffic(165);
      test_pause_until_drained();

      send_idle_pct = 69;
      recv_idle_pct = 29;
      test_random_traffic(165);

      send_idle_pct = 0;
      recv_idle_pct = 0;
      test_random_traffic(165);

      drain_results();
      repeat (8) @(posedge clock);
      if (error_count == 0 && expected_line_states.size() == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

endmodule
